FILE: rtl/core/gtlj_pkg.sv
package gtlj_pkg;

	// Default and upper limit of the line buffer width.
	localparam int MAX_W_DEF = 32;
	// Counter width, sized for the largest supported line width.
	localparam int CNT_W = 6;
	// Width of sums of three counters.
	localparam int SUM_W = CNT_W + 2;
	// Width of the line_width register.
	localparam int LW_W = 6;
	localparam logic [LW_W-1:0] LW_RESET = 6'd16;
	localparam logic [7:0] SPACE_CODE = 8'd32;

	// One classified character on its way from the front to the back.
	typedef struct packed {
		logic [7:0]       ch;
		logic             wr;
		logic [CNT_W-1:0] k;
		logic             ew;
		logic             et;
		logic [CNT_W-1:0] wl;
		logic             flag;
	} entry_t;

	// One output character.
	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
		logic       flag;
		logic       last;
	} result_t;

endpackage

FILE: rtl/core/gtlj_fifo.sv
module gtlj_fifo import gtlj_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/core/gtlj_front.sv
module gtlj_front import gtlj_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       char_code,
	input  logic             ends_word,
	input  logic             ends_text,
	input  logic [CNT_W-1:0] weff,
	output logic             q_push,
	output entry_t           q_entry,
	input  logic             q_full
);

	logic [CNT_W-1:0] count_q;
	logic             trunc_q;
	logic             ew, wr, accept;
	logic [CNT_W-1:0] ncount;

	always_comb begin
		ew     = ends_word | ends_text;
		wr     = (count_q < weff);
		ncount = wr ? count_q + 1'b1 : count_q;
		accept = push && !q_full;

		q_entry.ch   = char_code;
		q_entry.wr   = wr;
		q_entry.k    = count_q;
		q_entry.ew   = ew;
		q_entry.et   = ends_text;
		q_entry.wl   = (ncount > weff) ? weff : ncount;
		q_entry.flag = trunc_q | !wr | (ncount > weff);
	end

	assign full   = q_full;
	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			if (ew) begin
				count_q <= '0;
				trunc_q <= 1'b0;
			end else begin
				count_q <= ncount;
				trunc_q <= trunc_q | !wr;
			end
		end
	end

endmodule

FILE: rtl/core/gtlj_back.sv
module gtlj_back import gtlj_pkg::*; #(
	parameter int MAX_WIDTH = MAX_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] weff,
	input  logic             q_empty,
	input  entry_t           q_entry,
	output logic             q_pop,
	output logic             res_push,
	output result_t          res,
	input  logic             res_full
);

	localparam int AW    = $clog2(2 * MAX_WIDTH);
	localparam int DEPTH = 1 << AW;
	localparam int DCW   = $clog2(CNT_W);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} state_t;

	typedef struct packed {
		logic [AW-1:0]    base;
		logic [CNT_W-1:0] letters;
		logic [CNT_W-1:0] words;
		logic             last;
		logic             flag;
		logic             rl;
	} job_t;

	logic [7:0] buf_mem [DEPTH];
	logic       mark_mem [DEPTH];
	logic [7:0] rd_ch_q;
	logic       rd_mk_q;

	state_t           state_q;
	logic [AW-1:0]    base_q;
	logic [CNT_W-1:0] letters_q, words_q;
	job_t             cur_q, pend_q;
	logic             pend_v_q;
	logic [DCW-1:0]   divcnt_q;
	logic [CNT_W-1:0] quo_q, rem_q, gaps_q;
	logic             just_q;
	logic [CNT_W-1:0] i_q, pos_q, gi_q;
	logic [CNT_W:0]   spc_q;
	logic             gap_q;

	// Item decision.
	logic [SUM_W-1:0] sum1, sum2;
	logic             e1, e2, take;
	logic [AW-1:0]    base2, waddr, raddr;
	logic [CNT_W-1:0] let2, words2;
	job_t             job_a, job_b, nj;
	logic             load;

	// Emission.
	logic             have_let, gap_needed, can, line_done;
	logic [CNT_W:0]   cnt;
	logic [CNT_W-1:0] i_d;
	logic [CNT_W:0]   trial;
	logic             just_n;

	always_comb begin
		take   = (state_q == ST_IDLE) && !q_empty;
		sum1   = SUM_W'(letters_q) + SUM_W'(words_q) + SUM_W'(q_entry.wl);
		e1     = q_entry.ew && (words_q != '0) && (sum1 > SUM_W'(weff));
		base2  = e1 ? base_q + AW'(letters_q) : base_q;
		let2   = e1 ? q_entry.wl : letters_q + q_entry.wl;
		words2 = e1 ? CNT_W'(1) : words_q + 1'b1;
		sum2   = SUM_W'(let2) + SUM_W'(words2);
		e2     = q_entry.et || (sum2 >= SUM_W'(weff));
		waddr  = base_q + AW'(letters_q) + AW'(q_entry.k);

		job_a = '{base: base_q, letters: letters_q, words: words_q,
			last: 1'b0, flag: 1'b0, rl: !e2};
		job_b = '{base: base2, letters: let2, words: words2,
			last: q_entry.et, flag: q_entry.flag, rl: 1'b1};

		can        = !res_full;
		have_let   = (i_q < cur_q.letters);
		gap_needed = have_let && (i_q != '0) && rd_mk_q && !gap_q;
		cnt        = just_q ? {1'b0, quo_q} + (CNT_W+1)'(gi_q < rem_q) : (CNT_W+1)'(1);
		line_done  = (state_q == ST_RUN) && can && (pos_q == weff - 1'b1);

		res.ch       = (have_let && !gap_needed) ? rd_ch_q : SPACE_CODE;
		res.line_end = (pos_q == weff - 1'b1);
		res.flag     = cur_q.flag;
		res.last     = cur_q.rl && res.line_end;
		res_push     = (state_q == ST_RUN) && can;
		q_pop        = take;

		// A new line job starts either from an item or from the pending job.
		if (take) begin
			load = q_entry.ew && (e1 || e2);
			nj   = e1 ? job_a : job_b;
		end else begin
			load = line_done && pend_v_q;
			nj   = pend_q;
		end
		just_n = !nj.last && (nj.words > CNT_W'(1)) &&
			(SUM_W'(nj.letters) + SUM_W'(nj.words) - 1'b1 <= SUM_W'(weff));

		i_d = i_q;
		if (load) begin
			i_d = '0;
		end else if (res_push && have_let && !gap_needed) begin
			i_d = i_q + 1'b1;
		end
		raddr = (load ? nj.base : cur_q.base) + AW'(i_d);

		trial = {rem_q, quo_q[CNT_W-1]};
	end

	always_ff @(posedge clk) begin
		if (take && q_entry.wr) begin
			buf_mem[waddr]  <= q_entry.ch;
			mark_mem[waddr] <= (q_entry.k == '0);
		end
		rd_ch_q <= buf_mem[raddr];
		rd_mk_q <= mark_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			letters_q <= '0;
			words_q   <= '0;
			cur_q     <= '0;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			divcnt_q  <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			gaps_q    <= '0;
			just_q    <= 1'b0;
			i_q       <= '0;
			pos_q     <= '0;
			gi_q      <= '0;
			spc_q     <= '0;
			gap_q     <= 1'b0;
		end else begin
			i_q <= i_d;
			if (take && q_entry.ew) begin
				if (e2) begin
					base_q    <= base2 + AW'(let2);
					letters_q <= '0;
					words_q   <= '0;
				end else begin
					base_q    <= base2;
					letters_q <= let2;
					words_q   <= words2;
				end
				pend_q   <= job_b;
				pend_v_q <= e1 && e2;
			end

			case (state_q)
				ST_DIV: begin
					if (trial >= {1'b0, gaps_q}) begin
						rem_q <= CNT_W'(trial - {1'b0, gaps_q});
						quo_q <= {quo_q[CNT_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[CNT_W-1:0];
						quo_q <= {quo_q[CNT_W-2:0], 1'b0};
					end
					divcnt_q <= divcnt_q + 1'b1;
					if (divcnt_q == DCW'(CNT_W - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (can) begin
						pos_q <= pos_q + 1'b1;
						if (gap_needed) begin
							if (spc_q + 1'b1 == cnt) begin
								gap_q <= 1'b1;
								gi_q  <= gi_q + 1'b1;
								spc_q <= '0;
							end else begin
								spc_q <= spc_q + 1'b1;
							end
						end else if (have_let) begin
							gap_q <= 1'b0;
						end
						if (line_done) begin
							state_q <= ST_IDLE;
							if (pend_v_q) begin
								pend_v_q <= 1'b0;
							end
						end
					end
				end
				default: ;
			endcase

			if (load) begin
				state_q  <= ST_DIV;
				cur_q    <= nj;
				divcnt_q <= '0;
				quo_q    <= weff - nj.letters;
				rem_q    <= '0;
				gaps_q   <= nj.words - 1'b1;
				just_q   <= just_n;
				pos_q    <= '0;
				gi_q     <= '0;
				spc_q    <= '0;
				gap_q    <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/greedy_text_line_justifier.sv
// Greedy full text justification, one character per request on each side.
// Input channel: the writer drives char_code, ends_word and ends_text and raises
// push; a request is taken at a clock edge where push is high and full is low.
// Every character is a non-space letter; ends_word marks the last letter of a
// word and ends_text the last letter of the text (it also ends the word).
// Output channel: while empty is low the oldest output character is on
// out_char, with line_end on the last character of each line, word_truncated
// on every character of a line that held a cut word, and run_last on the last
// character caused by one input request. It is taken when pop is high.
// Configuration: line_width is written when line_width_we is high. It is to be
// written only while the block is idle; the block itself does not enforce this.
// Zero acts as one, values above MAX_WIDTH as MAX_WIDTH. Operation: the back
// end absorbs a request that ends no line while it is idle. A line adds a serial
// divide for the gap spacing, then the effective width of output characters,
// one per cycle while the output queue has room.
// While the receiver stalls, the back end holds its line and the two-entry
// request queue fills, after which full rises. Reset empties both queues and
// clears the line and word state; the buffer contents need no clearing.
module greedy_text_line_justifier import gtlj_pkg::*; #(
	parameter int MAX_WIDTH = MAX_W_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            line_width_we,
	input  logic [LW_W-1:0] line_width,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      char_code,
	input  logic            ends_word,
	input  logic            ends_text,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_char,
	output logic            line_end,
	output logic            word_truncated,
	output logic            run_last
);

	logic [LW_W-1:0]  line_width_q;
	logic [CNT_W-1:0] weff;

	logic    q_push, q_full, q_empty, q_pop;
	entry_t  q_in, q_out;
	logic    res_push, res_full;
	result_t res_in, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_RESET;
		end else if (line_width_we) begin
			line_width_q <= line_width;
		end
	end

	// Effective width, clamped to the supported range.
	always_comb begin
		if (line_width_q == '0) begin
			weff = CNT_W'(1);
		end else if (CNT_W'(line_width_q) > CNT_W'(MAX_WIDTH)) begin
			weff = CNT_W'(MAX_WIDTH);
		end else begin
			weff = CNT_W'(line_width_q);
		end
	end

	gtlj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.ends_word (ends_word),
		.ends_text (ends_text),
		.weff      (weff),
		.q_push    (q_push),
		.q_entry   (q_in),
		.q_full    (q_full)
	);

	// Short queue between the front and the back.
	gtlj_fifo #(.W($bits(entry_t)), .DEPTH(2)) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_out),
		.empty   (q_empty)
	);

	gtlj_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.weff     (weff),
		.q_empty  (q_empty),
		.q_entry  (q_out),
		.q_pop    (q_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full)
	);

	// Output queue; it lets the back end run ahead of a slow receiver.
	gtlj_fifo #(.W($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign out_char       = res_out.ch;
	assign line_end       = res_out.line_end;
	assign word_truncated = res_out.flag;
	assign run_last       = res_out.last;

endmodule

FILE: rtl/core/gtlj_checker.sv
module gtlj_checker import gtlj_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            line_width_we,
	input logic [LW_W-1:0] line_width,
	input logic            push,
	input logic            full,
	input logic [7:0]      char_code,
	input logic            ends_word,
	input logic            ends_text,
	input logic            empty,
	input logic            pop,
	input logic [7:0]      out_char,
	input logic            line_end,
	input logic            word_truncated,
	input logic            run_last
);

	// Reset leaves no output waiting.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("output not empty in reset");

	// Reset leaves room for input.
	a_reset_room: assert property (@(posedge clk) !arst_n |=> !full)
		else $error("input full in reset");

	// The last output of a request always closes a line.
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && run_last) |-> line_end)
		else $error("run_last without line_end");

	// A waiting output holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_char) && $stable(line_end)))
		else $error("waiting output changed");

endmodule

bind greedy_text_line_justifier gtlj_checker u_gtlj_checker (.*);

FILE: tb/testbench.sv
module testbench;
	import gtlj_pkg::*;

	localparam int MAXW = 32;
	localparam int CYCLE_LIMIT = 2000000;

	// One expected output character.
	typedef struct {
		logic [7:0] ch;
		logic       line_end;
		logic       flag;
		logic       last;
	} char_exp_t;

	// The scoreboard holds a copy of the justifier state and the queue of
	// characters that the block still owes.
	class justify_board;
		int unsigned width_reg;
		byte unsigned line_chars[MAXW];
		bit line_starts[MAXW];
		int unsigned line_letters, line_words;
		byte unsigned word_chars[MAXW];
		int unsigned word_letters;
		bit cut_seen;
		char_exp_t owed[$];
		int errors;

		function new();
			width_reg = 16;
			line_letters = 0;
			line_words = 0;
			word_letters = 0;
			cut_seen = 0;
			errors = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < 1) return 1;
			if (width_reg > MAXW) return MAXW;
			return width_reg;
		endfunction

		function void put_char(ref int unsigned pos, input int unsigned w,
			input logic [7:0] ch, input bit flag);
			char_exp_t e;
			if (pos >= w) return;
			e.ch = ch;
			e.line_end = (pos + 1 == w);
			e.flag = flag;
			e.last = 0;
			owed.insert(owed.size(), e);
			pos++;
		endfunction

		// Lays out the buffered line at full width and queues its characters.
		function void lay_out_line(bit flag, bit final_line, ref int produced);
			int unsigned w, letters, gaps, sp, extra, gi, pos, cnt, before_n;
			w = eff_width();
			letters = line_letters;
			sp = 1;
			extra = 0;
			gi = 0;
			pos = 0;
			if (line_words == 0) return;
			before_n = owed.size();
			if (letters > MAXW) letters = MAXW;
			gaps = line_words - 1;
			if (!final_line && gaps > 0 && letters + gaps <= w) begin
				sp = (w - letters) / gaps;
				extra = (w - letters) % gaps;
			end
			for (int i = 0; i < letters; i++) begin
				if (i > 0 && line_starts[i]) begin
					cnt = sp + ((gi < extra) ? 1 : 0);
					gi++;
					for (int c = 0; c < cnt; c++)
						put_char(pos, w, SPACE_CODE, flag);
				end
				put_char(pos, w, line_chars[i], flag);
			end
			while (pos < w)
				put_char(pos, w, SPACE_CODE, flag);
			produced += owed.size() - before_n;
			line_letters = 0;
			line_words = 0;
		endfunction

		// Notes an accepted request and queues the characters it causes.
		function void note_request(logic [7:0] ch, bit ew_in, bit et);
			int unsigned w, wl, start;
			int produced;
			bit ew, flag;
			w = eff_width();
			ew = ew_in | et;
			produced = 0;
			if (word_letters < w) begin
				word_chars[word_letters] = ch;
				word_letters++;
			end else begin
				cut_seen = 1;
			end
			if (!ew) return;
			wl = word_letters;
			if (wl > w) begin
				wl = w;
				cut_seen = 1;
			end
			if (line_words > 0 && line_letters + line_words + wl > w)
				lay_out_line(0, 0, produced);
			start = line_letters;
			for (int i = 0; i < wl; i++) begin
				if (start + i >= MAXW) break;
				line_chars[start + i] = word_chars[i];
				line_starts[start + i] = (i == 0);
				line_letters = start + i + 1;
			end
			if (line_words < MAXW) line_words++;
			word_letters = 0;
			flag = cut_seen;
			cut_seen = 0;
			if (et)
				lay_out_line(flag, 1, produced);
			else if (line_letters + line_words >= w)
				lay_out_line(flag, 0, produced);
			if (produced > 0) owed[owed.size() - 1].last = 1;
		endfunction

		// Compares one accepted output character with the oldest owed one.
		function void check_char(logic [7:0] ch, logic le, logic fl, logic rl);
			char_exp_t e;
			if (owed.size() == 0) begin
				$error("unexpected output character %0d", ch);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (ch !== e.ch) begin
				$error("out_char expected %0d actual %0d", e.ch, ch);
				errors++;
			end
			if (le !== e.line_end) begin
				$error("line_end expected %0d actual %0d", e.line_end, le);
				errors++;
			end
			if (fl !== e.flag) begin
				$error("word_truncated expected %0d actual %0d", e.flag, fl);
				errors++;
			end
			if (rl !== e.last) begin
				$error("run_last expected %0d actual %0d", e.last, rl);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic line_width_we = 0;
	logic [LW_W-1:0] line_width = LW_RESET;
	logic push = 0;
	logic full;
	logic [7:0] char_code = 0;
	logic ends_word = 0;
	logic ends_text = 0;
	logic empty;
	logic pop = 0;
	logic [7:0] out_char;
	logic line_end, word_truncated, run_last;

	justify_board board;
	int cycle_count = 0;

	greedy_text_line_justifier dut (
		.clk(clk), .arst_n(arst_n),
		.line_width_we(line_width_we), .line_width(line_width),
		.push(push), .full(full),
		.char_code(char_code), .ends_word(ends_word), .ends_text(ends_text),
		.empty(empty), .pop(pop),
		.out_char(out_char), .line_end(line_end),
		.word_truncated(word_truncated), .run_last(run_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The run is stopped outright when it takes far too long.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// The receiver: a random stall is drawn per character, and pop is raised
	// once it has passed. A character is taken on an edge with pop high and
	// empty low, sampled at that edge.
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1;
			do @(posedge clk); while (empty);
			board.check_char(out_char, line_end, word_truncated, run_last);
		end
	end

	// Sends one character and returns once it has been accepted. Push stays
	// high across back-to-back requests, so it is never dropped and raised in
	// the same step.
	task automatic send_char(logic [7:0] ch, bit ew, bit et, bit keep_up);
		char_code <= ch;
		ends_word <= ew;
		ends_text <= et;
		push <= 1;
		do @(posedge clk); while (full);
		board.note_request(ch, ew, et);
		if (!keep_up) push <= 0;
	endtask

	// One request with a random gap in front of it.
	task automatic send_paced(logic [7:0] ch, bit ew, bit et);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		send_char(ch, ew, et, 1);
	endtask

	// Waits until every owed character has come, then for the longest line
	// time so that no line is still being prepared.
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (board.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// The width is written only while the block holds no line being emitted; a partly filled line may still be buffered.
	task automatic set_width(logic [LW_W-1:0] val);
		drain();
		line_width <= val;
		line_width_we <= 1;
		@(posedge clk);
		line_width_we <= 0;
		board.width_reg = val;
	endtask

	// A word of random letters; the text may end with it.
	task automatic send_word(int len, bit ends);
		for (int i = 0; i < len; i++)
			send_paced(8'($urandom_range(0, 255)), i == len - 1,
				ends && (i == len - 1));
	endtask

	function automatic int word_len(int w);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(1, w + 4);
		return $urandom_range(1, (w < 8) ? w : 8);
	endfunction

	initial begin
		int w;
		logic [LW_W-1:0] widths[7] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd2, 6'd20};
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part at the reset width of sixteen.
		send_char(8'h00, 1, 0, 1);                  // lowest code, one-letter word
		send_char(8'hFF, 0, 0, 1);
		send_char(8'hA5, 1, 0, 1);
		send_char(8'h5A, 1, 0, 1);
		// A word far longer than the line is cut and flagged.
		for (int i = 0; i < 20; i++) send_char(8'(65 + i), i == 19, 0, 1);
		send_char(8'h41, 0, 1, 1);                  // end of text without end of word
		send_char(8'h42, 1, 0, 1);
		send_char(8'h43, 1, 1, 1);                  // final line with single spaces
		drain();

		// A buffered line that no longer fits after a narrower width is set.
		send_char(8'h61, 0, 0, 1);
		send_char(8'h62, 1, 0, 1);
		send_char(8'h63, 0, 0, 1);
		send_char(8'h64, 1, 0, 1);
		set_width(6'd3);
		send_char(8'h65, 1, 1, 1);
		set_width(6'd16);

		// Random text in phases over several widths, the extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) set_width(widths[ph - 1]);
			w = board.eff_width();
			for (int k = 0; k < 12; k++) begin
				if ($urandom_range(0, 15) == 0) begin
					// Noise: a lone character with random marks.
					send_paced(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1,
						$urandom_range(0, 5) == 0);
				end else begin
					send_word(word_len(w), $urandom_range(0, 7) == 0);
				end
				if (ph == 3 && k == 6) drain();
			end
			send_word(1, 1);
		end

		drain();
		if (board.errors == 0 && board.owed.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
